/* rtl/hlw_pkg.sv */
// shared types, constants and rounding helper for the hex line walker
package hlw_pkg;

  localparam int COORD_BITS  = 11;
  localparam int MAX_STEPS   = 63;
  localparam int STEP_BITS   = $clog2(MAX_STEPS + 1);
  localparam int DELTA_BITS  = STEP_BITS + 1;
  localparam int RSUM_BITS   = STEP_BITS + 2;
  localparam int DIFF_BITS   = COORD_BITS + 1;
  localparam int KEY_BITS    = STEP_BITS + 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // command classes decided by the front end
  typedef enum logic [1:0] {
    KIND_WALK   = 2'd0,
    KIND_SINGLE = 2'd1,
    KIND_FAR    = 2'd2
  } kind_t;

  // back end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } back_state_t;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [DELTA_BITS-1:0] delta_t;
  typedef logic [STEP_BITS-1:0]  step_t;

  // one classified line request
  typedef struct packed {
    kind_t                         kind;
    logic                          pos;
    logic [2:0][COORD_BITS-1:0]    org;
    logic [2:0][DELTA_BITS-1:0]    dl;
    step_t                         span;
  } cmd_t;

  // rounding decision of one axis
  typedef struct packed {
    logic                 up;
    logic [KEY_BITS-1:0]  key;
  } axis_rnd_t;

  // round rem/span to nearest with the nudge sign s, and build a residue key
  // in which the residue magnitude dominates and the nudge term breaks ties
  function automatic axis_rnd_t axis_round(input step_t rem, input step_t span,
                                           input logic s_pos, input logic s_big);
    axis_rnd_t          res;
    logic [STEP_BITS:0] twice;
    logic               up;
    logic               neg;
    step_t              mag;
    logic [3:0]         coef_off;
    twice = {rem, 1'b0};
    up    = (twice > {1'b0, span}) || ((twice == {1'b0, span}) && s_pos);
    mag   = up ? step_t'(span - rem) : rem;
    // rounded up: coef is -s; rounded down with residue: +s; exact: |s|
    neg   = up ? s_pos : ((rem != '0) ? !s_pos : 1'b0);
    if (neg) begin
      coef_off = s_big ? 4'd6 : 4'd7;
    end else begin
      coef_off = s_big ? 4'd10 : 4'd9;
    end
    res.up  = up;
    res.key = {mag, coef_off};
    return res;
  endfunction

endpackage

/* rtl/hex_line_walker_core.sv */
// top level of the cube coordinate hex line walker
//
// Input channel (in_valid/in_ready): one request per transfer, a start hex,
// an end hex in cube coordinates and a nudge direction for ties.
// Output channel (out_valid/out_ready): the hexes of the line, start first,
// one per transfer, with last set on the final one. A request whose
// distance exceeds the step limit gives one result with too_far and last
// set and zero coordinates; a zero distance request gives the start hex once.
// The front end registers and classifies a request and hands it through a
// two entry queue to the back end, so new requests are taken while a line
// is still being walked. A walked line passes the front register, the queue,
// the back end's line registers and then the result register; a single or
// too-far result goes from the queue straight into the result register. The
// back end loads a line of distance D and then steps out its D+1 hexes (up
// to 64); it takes the next request from the queue only after the last hex
// of a line. When the receiver stalls the result register holds, the back
// end waits, and the queue and front end fill before in_ready drops.
// Synchronous reset empties the queue and the result register.
module hex_line_walker_core import hlw_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  coord_t start_x,
  input  coord_t start_y,
  input  coord_t start_z,
  input  coord_t end_x,
  input  coord_t end_y,
  input  coord_t end_z,
  input  logic   nudge_positive,
  output logic   out_valid,
  input  logic   out_ready,
  output coord_t hex_x,
  output coord_t hex_y,
  output coord_t hex_z,
  output logic   last,
  output logic   too_far
);

  logic f_valid;
  logic f_ready;
  cmd_t f_cmd;
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  // request register and classifier
  hlw_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .start_x        (start_x),
    .start_y        (start_y),
    .start_z        (start_z),
    .end_x          (end_x),
    .end_y          (end_y),
    .end_z          (end_z),
    .nudge_positive (nudge_positive),
    .cmd_valid      (f_valid),
    .cmd            (f_cmd),
    .cmd_ready      (f_ready)
  );

  // decoupling queue
  hlw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd)
  );

  // line stepper and result register
  hlw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_pop   (q_pop),
    .cmd_in    (q_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hex_x     (hex_x),
    .hex_y     (hex_y),
    .hex_z     (hex_z),
    .last      (last),
    .too_far   (too_far)
  );

  // a too-far result is always the only, final result of its request
  a_far_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && too_far) |-> (last && (hex_x == '0) && (hex_y == '0) && (hex_z == '0)))
    else $error("too_far result not final or not zero");

  // every hex before the end of a walked line lies on the zero-sum plane
  a_plane: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> ((hex_x + hex_y + hex_z) == coord_t'(0)))
    else $error("line hex off the cube plane");

  // reset empties the result register
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

/* rtl/hlw_front.sv */
// front end: input register, axis deltas, distance and request class
module hlw_front import hlw_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  coord_t start_x,
  input  coord_t start_y,
  input  coord_t start_z,
  input  coord_t end_x,
  input  coord_t end_y,
  input  coord_t end_z,
  input  logic   nudge_positive,
  output logic   cmd_valid,
  output cmd_t   cmd,
  input  logic   cmd_ready
);

  logic [2:0][COORD_BITS-1:0] org;
  logic [2:0][COORD_BITS-1:0] dst;
  logic signed [DIFF_BITS-1:0] diff [3];
  logic [DIFF_BITS-1:0]        mag  [3];
  logic [DIFF_BITS-1:0]        dist_w;
  cmd_t                        cmd_next;

  assign org = {start_z, start_y, start_x};
  assign dst = {end_z, end_y, end_x};

  // per axis difference and magnitude
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = $signed({dst[k][COORD_BITS-1], dst[k]})
              - $signed({org[k][COORD_BITS-1], org[k]});
      mag[k]  = diff[k][DIFF_BITS-1] ? DIFF_BITS'(-diff[k]) : DIFF_BITS'(diff[k]);
    end
  end

  // distance is the largest axis magnitude
  always_comb begin
    dist_w = mag[0];
    if (mag[1] > dist_w) begin
      dist_w = mag[1];
    end
    if (mag[2] > dist_w) begin
      dist_w = mag[2];
    end
  end

  // classify the request
  always_comb begin
    cmd_next.pos  = nudge_positive;
    cmd_next.org  = org;
    cmd_next.span = dist_w[STEP_BITS-1:0];
    for (int k = 0; k < 3; k++) begin
      cmd_next.dl[k] = diff[k][DELTA_BITS-1:0];
    end
    if (dist_w > DIFF_BITS'(MAX_STEPS)) begin
      cmd_next.kind = KIND_FAR;
    end else if (dist_w == '0) begin
      cmd_next.kind = KIND_SINGLE;
    end else begin
      cmd_next.kind = KIND_WALK;
    end
  end

  assign in_ready = !cmd_valid || cmd_ready;

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      cmd_valid <= 1'b1;
    end else if (cmd_ready) begin
      cmd_valid <= 1'b0;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd <= cmd_next;
    end
  end

endmodule

/* rtl/hlw_queue.sv */
// short command queue between front and back end
module hlw_queue import hlw_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop,
  output cmd_t pop_cmd
);

  cmd_t                 slot [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = (count != QCNT_BITS'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = slot[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= push_cmd;
    end
  end

endmodule

/* rtl/hlw_back.sv */
// back end: steps along the line and drives the result register
module hlw_back import hlw_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   cmd_valid,
  output logic   cmd_pop,
  input  cmd_t   cmd_in,
  output logic   out_valid,
  input  logic   out_ready,
  output coord_t hex_x,
  output coord_t hex_y,
  output coord_t hex_z,
  output logic   last,
  output logic   too_far
);

  back_state_t                state;
  cmd_t                       cur;
  step_t                      step;
  logic [2:0][DELTA_BITS-1:0] quo;
  logic [2:0][STEP_BITS-1:0]  rem;

  logic                       adv;
  logic                       is_last;
  axis_rnd_t                  rnd [3];
  coord_t                     rc  [3];
  coord_t                     res [3];
  logic [2:0][DELTA_BITS-1:0] quo_next;
  logic [2:0][STEP_BITS-1:0]  rem_next;
  logic signed [RSUM_BITS-1:0] rsum [3];
  logic signed [RSUM_BITS-1:0] dsig;

  assign adv     = !out_valid || out_ready;
  assign cmd_pop = (state == ST_IDLE) && adv && cmd_valid;
  assign is_last = (step == cur.span);
  assign dsig    = $signed({2'b00, cur.span});

  // round each axis of the current point and sum with the origin
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rnd[k] = axis_round(rem[k], cur.span, (k < 2) ? cur.pos : !cur.pos, (k == 2));
      rc[k]  = cur.org[k]
             + {{(COORD_BITS-DELTA_BITS){quo[k][DELTA_BITS-1]}}, quo[k]}
             + COORD_BITS'(rnd[k].up);
    end
  end

  // recompute the axis with the largest residue from the other two
  always_comb begin
    res[0] = rc[0];
    res[1] = rc[1];
    res[2] = rc[2];
    priority if ((rnd[0].key > rnd[1].key) && (rnd[0].key > rnd[2].key)) begin
      res[0] = coord_t'('0) - rc[1] - rc[2];
    end else if (rnd[1].key > rnd[2].key) begin
      res[1] = coord_t'('0) - rc[0] - rc[2];
    end else begin
      res[2] = coord_t'('0) - rc[0] - rc[1];
    end
  end

  // advance the floor quotient and remainder by one delta
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rsum[k] = $signed({2'b00, rem[k]}) + $signed({cur.dl[k][DELTA_BITS-1], cur.dl[k]});
      if (rsum[k] >= dsig) begin
        rem_next[k] = STEP_BITS'(rsum[k] - dsig);
        quo_next[k] = quo[k] + 1'b1;
      end else if (rsum[k] < 0) begin
        rem_next[k] = STEP_BITS'(rsum[k] + dsig);
        quo_next[k] = quo[k] - 1'b1;
      end else begin
        rem_next[k] = rsum[k][STEP_BITS-1:0];
        quo_next[k] = quo[k];
      end
    end
  end

  // sequencer and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd_pop) begin
            if (cmd_in.kind == KIND_WALK) begin
              state     <= ST_RUN;
              out_valid <= 1'b0;
            end else begin
              out_valid <= 1'b1;
            end
          end else if (adv) begin
            out_valid <= 1'b0;
          end
        end
        ST_RUN: begin
          if (adv) begin
            out_valid <= 1'b1;
            if (is_last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state     <= ST_IDLE;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

  // line state and result payload
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      unique case (cmd_in.kind)
        KIND_FAR: begin
          hex_x   <= '0;
          hex_y   <= '0;
          hex_z   <= '0;
          last    <= 1'b1;
          too_far <= 1'b1;
        end
        KIND_SINGLE: begin
          hex_x   <= cmd_in.org[0];
          hex_y   <= cmd_in.org[1];
          hex_z   <= cmd_in.org[2];
          last    <= 1'b1;
          too_far <= 1'b0;
        end
        KIND_WALK: begin
          cur  <= cmd_in;
          step <= '0;
          quo  <= '0;
          rem  <= '0;
        end
        default: begin
          cur <= cmd_in;
        end
      endcase
    end else if ((state == ST_RUN) && adv) begin
      hex_x   <= res[0];
      hex_y   <= res[1];
      hex_z   <= res[2];
      last    <= is_last;
      too_far <= 1'b0;
      step    <= step + 1'b1;
      quo     <= quo_next;
      rem     <= rem_next;
    end
  end

endmodule

/* bench/tb.sv */
// self-checking testbench for the hex line walker core
`timescale 1ns / 1ps

typedef struct {
  hlw_pkg::coord_t x;
  hlw_pkg::coord_t y;
  hlw_pkg::coord_t z;
  logic            last;
  logic            far;
} line_hex_t;

// walks each accepted request into its hexes and checks results in order
class line_scoreboard;
  line_hex_t pending_hexes[$];
  int        errors;
  int        mismatches;
  int        hexes_seen;
  int        far_lines;
  int        point_lines;
  // line registers as the walker holds them
  longint    org[3];
  longint    dlt[3];
  longint    span;

  function new();
    errors      = 0;
    mismatches  = 0;
    hexes_seen  = 0;
    far_lines   = 0;
    point_lines = 0;
    span        = 0;
    foreach (org[k]) begin
      org[k] = 0;
      dlt[k] = 0;
    end
  endfunction

  // nearest rounding of num/d with nudge sign s; key ranks the residue
  function longint round_coord(longint num, longint d, int s, output longint key);
    longint q;
    longint rem;
    longint diff;
    int     coef;
    q   = num / d;
    rem = num % d;
    if (rem < 0) begin
      q   = q - 1;
      rem = rem + d;
    end
    if (2 * rem > d || (2 * rem == d && s > 0)) q = q + 1;
    diff = q * d - num;
    if (diff > 0) coef = -s;
    else if (diff < 0) coef = s;
    else coef = (s < 0) ? -s : s;
    key = ((diff < 0) ? -diff : diff) * 16 + coef + 8;
    return q;
  endfunction

  // one accepted request: queue every hex of its line
  function void walk_request(hlw_pkg::coord_t sx, hlw_pkg::coord_t sy, hlw_pkg::coord_t sz,
                             hlw_pkg::coord_t ex, hlw_pkg::coord_t ey, hlw_pkg::coord_t ez,
                             logic pos);
    longint    a[3];
    longint    e[3];
    longint    d[3];
    longint    key[3];
    longint    r[3];
    longint    steps;
    longint    mag;
    int        sg[3];
    line_hex_t h;
    a[0] = longint'($signed(sx));
    a[1] = longint'($signed(sy));
    a[2] = longint'($signed(sz));
    e[0] = longint'($signed(ex));
    e[1] = longint'($signed(ey));
    e[2] = longint'($signed(ez));
    steps = 0;
    for (int k = 0; k < 3; k++) begin
      d[k] = e[k] - a[k];
      mag  = (d[k] < 0) ? -d[k] : d[k];
      if (mag > steps) steps = mag;
    end
    // beyond the step limit: one flagged result, line registers untouched
    if (steps > hlw_pkg::MAX_STEPS) begin
      h.x = '0;
      h.y = '0;
      h.z = '0;
      h.last = 1'b1;
      h.far  = 1'b1;
      pending_hexes.insert(pending_hexes.size(), h);
      far_lines++;
      return;
    end
    org  = a;
    dlt  = d;
    span = steps;
    h.far = 1'b0;
    // zero distance: the start hex alone
    if (steps == 0) begin
      h.x = hlw_pkg::coord_t'(a[0]);
      h.y = hlw_pkg::coord_t'(a[1]);
      h.z = hlw_pkg::coord_t'(a[2]);
      h.last = 1'b1;
      pending_hexes.insert(pending_hexes.size(), h);
      point_lines++;
      return;
    end
    sg[0] = pos ? 1 : -1;
    sg[1] = pos ? 1 : -1;
    sg[2] = pos ? -2 : 2;
    for (longint i = 0; i <= steps; i++) begin
      for (int k = 0; k < 3; k++) begin
        r[k] = round_coord(org[k] * span + dlt[k] * i, span, sg[k], key[k]);
      end
      // the axis with the largest residue is rebuilt from the other two
      if (key[0] > key[1] && key[0] > key[2]) r[0] = -r[1] - r[2];
      else if (key[1] > key[2]) r[1] = -r[0] - r[2];
      else r[2] = -r[0] - r[1];
      h.x = hlw_pkg::coord_t'(r[0]);
      h.y = hlw_pkg::coord_t'(r[1]);
      h.z = hlw_pkg::coord_t'(r[2]);
      h.last = (i == steps);
      pending_hexes.insert(pending_hexes.size(), h);
    end
  endfunction

  // one result transfer against the oldest queued hex
  function void check_hex(hlw_pkg::coord_t x, hlw_pkg::coord_t y, hlw_pkg::coord_t z,
                          logic lst, logic far);
    line_hex_t want;
    hexes_seen++;
    if (pending_hexes.size() == 0) begin
      errors++;
      if (mismatches < 10)
        $display("result %0d with no hex pending: (%0d,%0d,%0d) last %b too_far %b",
                 hexes_seen, $signed(x), $signed(y), $signed(z), lst, far);
      mismatches++;
      return;
    end
    want = pending_hexes.pop_front();
    if (want.x !== x || want.y !== y || want.z !== z || want.last !== lst ||
        want.far !== far) begin
      errors++;
      if (mismatches < 10)
        $display("result %0d: want (%0d,%0d,%0d) %b %b, got (%0d,%0d,%0d) %b %b",
                 hexes_seen, $signed(want.x), $signed(want.y), $signed(want.z),
                 want.last, want.far, $signed(x), $signed(y), $signed(z), lst, far);
      mismatches++;
    end
  endfunction
endclass

module tb;
  import hlw_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_LINES = 100;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_ready;
  coord_t start_x = '0;
  coord_t start_y = '0;
  coord_t start_z = '0;
  coord_t end_x = '0;
  coord_t end_y = '0;
  coord_t end_z = '0;
  logic   nudge_positive = 1'b0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  coord_t hex_x;
  coord_t hex_y;
  coord_t hex_z;
  logic   last;
  logic   too_far;

  line_scoreboard lines = new();
  bit calm = 1'b0;
  int cycle_count = 0;
  int sent = 0;

  always #2 clk = ~clk;

  hex_line_walker_core DUT (.*);

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL hex_line_walker_core");
      $finish;
    end
  end

  // one request transfer after a random gap
  task automatic send_request(int sx, int sy, int sz, int ex, int ey, int ez, bit pos);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start_x <= coord_t'(sx);
    start_y <= coord_t'(sy);
    start_z <= coord_t'(sz);
    end_x <= coord_t'(ex);
    end_y <= coord_t'(ey);
    end_z <= coord_t'(ez);
    nudge_positive <= pos;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    lines.walk_request(coord_t'(sx), coord_t'(sy), coord_t'(sz),
                       coord_t'(ex), coord_t'(ey), coord_t'(ez), pos);
    sent++;
  endtask

  // hold off new requests until every queued hex has come out
  task automatic drain_lines();
    in_valid <= 1'b0;
    while (lines.pending_hexes.size() != 0) @(posedge clk);
  endtask

  // random request: mostly proper cube lines, some loose and raw ones
  task automatic random_request();
    int sel;
    int reach;
    int rot;
    int sgn;
    int s[3];
    int d[3];
    int dr[3];
    sel   = $urandom_range(0, 99);
    reach = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 63) : $urandom_range(0, 12);
    if (sel < 65) begin
      // well-formed line between two proper cube hexes
      s[0] = int'($urandom_range(0, 900)) - 450;
      s[1] = int'($urandom_range(0, 900)) - 450;
      s[2] = -s[0] - s[1];
      sgn  = $urandom_range(0, 1) ? 1 : -1;
      d[0] = sgn * reach;
      d[1] = -sgn * int'($urandom_range(0, reach));
      d[2] = -d[0] - d[1];
      rot  = $urandom_range(0, 2);
      for (int k = 0; k < 3; k++) dr[(k + rot) % 3] = d[k];
    end else if (sel < 85) begin
      // any start bits, short independent offsets that may wrap
      for (int k = 0; k < 3; k++) begin
        s[k]  = int'($urandom);
        dr[k] = int'($urandom_range(0, 2 * reach)) - reach;
      end
    end else begin
      // raw fields
      for (int k = 0; k < 3; k++) begin
        s[k]  = int'($urandom);
        dr[k] = int'($urandom) - s[k];
      end
    end
    send_request(s[0], s[1], s[2], s[0] + dr[0], s[1] + dr[1], s[2] + dr[2],
                 $urandom_range(0, 1));
  endtask

  // result side: random stall, then wait for the transfer and check it
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 12);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      lines.check_hex(hex_x, hex_y, hex_z, last, too_far);
    end
  end

  // stimulus and final verdict
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // zero distance lines
    send_request(0, 0, 0, 0, 0, 0, 1);
    send_request(5, -3, -2, 5, -3, -2, 0);
    // half-way ties settled by the nudge, both directions
    send_request(0, 0, 0, 2, -1, -1, 1);
    send_request(0, 0, 0, 2, -1, -1, 0);
    send_request(0, 0, 0, 1, 1, -2, 1);
    send_request(0, 0, 0, 1, 1, -2, 0);
    send_request(0, 0, 0, 4, -2, -2, 0);
    send_request(0, 0, 0, 3, 0, -3, 1);
    send_request(7, 7, -14, 8, 6, -14, 1);
    // longest lines and the step limit
    send_request(0, 0, 0, 63, -63, 0, 1);
    send_request(0, 0, 0, 0, 63, -63, 0);
    send_request(0, 0, 0, -63, 0, 63, 1);
    send_request(0, 0, 0, -64, 32, 32, 0);
    send_request(0, 0, 0, 0, 0, 64, 1);
    send_request(-1024, 1023, 1, 1023, -1024, 1, 1);
    // coordinate extremes
    send_request(-1024, 1023, 1, -1021, 1021, 0, 0);
    send_request(1023, -1024, 1, 1020, -1020, 0, 1);
    // hexes off the x+y+z=0 plane, outputs wrap; then two more lines on it
    send_request(1023, 1023, 1023, 1022, 1023, 1023, 1);
    send_request(-1024, -1024, -1024, -1024, -1023, -1024, 0);
    send_request(-512, 511, 1, -480, 479, 1, 1);
    send_request(10, -20, 10, -30, 20, 10, 0);

    drain_lines();

    for (int n = 0; n < RANDOM_LINES; n++) begin
      // a stretch with neither side idling
      calm = (n >= 40 && n < 70);
      random_request();
    end
    calm = 1'b0;
    drain_lines();
    repeat (80) @(posedge clk);

    if (lines.pending_hexes.size() != 0) begin
      $display("%0d hexes never came out", lines.pending_hexes.size());
      lines.errors += lines.pending_hexes.size();
    end
    $display("covered %0d requests and %0d result transfers", sent, lines.hexes_seen);
    $display("%0d past the step limit, %0d zero distance, %0d mismatches",
             lines.far_lines, lines.point_lines, lines.mismatches);
    if (lines.errors == 0) begin
      $display("PASS hex_line_walker_core");
    end else begin
      $display("FAIL hex_line_walker_core");
    end
    $finish;
  end

endmodule

/* hex_line_walker_core.f */
rtl/hlw_pkg.sv
rtl/hlw_front.sv
rtl/hlw_queue.sv
rtl/hlw_back.sv
rtl/hex_line_walker_core.sv
bench/tb.sv
